// ----- rtl/core/mpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpd_pkg
// types and constants shared by the median point displacement block
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned SqW      = 34;
  localparam int unsigned DistW    = 17;
  localparam int unsigned CountW   = 11;
  localparam int unsigned MaxPairs = 1024;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic                     last_pair;
  } mpd_in_t;

  typedef struct packed {
    logic [DistW-1:0]  median_distance;
    logic [CountW-1:0] pair_count;
    logic              overflow;
  } mpd_out_t;

endpackage

// ----- rtl/core/median_point_displacement.sv -----
// ----------------------------------------------------------------------------
// median_point_displacement
// median of euclidean distances between matched point pairs
// ----------------------------------------------------------------------------
// Each pair transfer starts a shift-and-add unit that forms the squared
// distance one multiplier bit per cycle; the result is written to the pair
// store unless it is full, and only then is the next pair accepted. On the
// last pair the block finds the element of rank n/2 by counting, for each
// stored candidate c, how many entries are below it and how many equal it,
// one store read per cycle over one memory port. The square root then runs
// bit by bit and the result waits in an output register. No clearing pass
// is needed.
module median_point_displacement #(
  parameter int unsigned MAX_PAIRS = mpd_pkg::MaxPairs
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mpd_pkg::mpd_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mpd_pkg::mpd_out_t out_data_o
);
  import mpd_pkg::*;

  localparam int unsigned AddrW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned NW    = $clog2(MAX_PAIRS + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam logic [2:0] StCand = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [NW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d, last_q, last_d;
  logic [NW-1:0]    ci_q, ci_d, ji_q, ji_d, lt_q, lt_d, eq_q, eq_d;
  logic [SqW-1:0]   cand_q, cand_d, rd_q, med_q, med_d;
  logic             rdv_q, rdv_d;
  logic [AddrW-1:0] raddr;
  logic             rd_en;
  logic [SqW-1:0]   mem [MAX_PAIRS];
  mpd_out_t         res_q, res_d;

  logic             sq_start, sq_done, rt_start, rt_done;
  logic [SqW-1:0]   sq_val;
  logic [DistW-1:0] rt_val;
  logic [CoordW:0]  dx, dy;

  assign dx = {in_data_i.second_x[CoordW-1], in_data_i.second_x}
            - {in_data_i.first_x[CoordW-1], in_data_i.first_x};
  assign dy = {in_data_i.second_y[CoordW-1], in_data_i.second_y}
            - {in_data_i.first_y[CoordW-1], in_data_i.first_y};

  assign in_ready_o = (state_q == StIdle);
  assign sq_start   = in_valid_i && in_ready_o;

  mpd_sqdist u_sqdist (
    .clk_i, .rst_ni, .start_i(sq_start), .dx_i(dx), .dy_i(dy),
    .done_o(sq_done), .sq_o(sq_val)
  );

  mpd_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(rt_start), .val_i(med_q),
    .done_o(rt_done), .root_o(rt_val)
  );

  // scan: candidate ci, compare against entry ji; rd_q is the registered read data
  always_comb begin
    state_d = state_q; count_d = count_q; ovf_d = ovf_q; last_d = last_q;
    ci_d = ci_q; ji_d = ji_q; lt_d = lt_q; eq_d = eq_q; cand_d = cand_q;
    med_d = med_q; rdv_d = 1'b0; rd_en = 1'b0; raddr = '0;
    rt_start = 1'b0; res_d = res_q;
    unique case (state_q)
      StIdle: begin
        if (sq_start) begin
          last_d  = in_data_i.last_pair;
          state_d = StSq;
        end
      end
      StSq: begin
        if (sq_done) begin
          if (count_q < NW'(MAX_PAIRS)) count_d = count_q + NW'(1);
          else ovf_d = 1'b1;
          if (last_q) begin
            ci_d = '0;
            state_d = StCand;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StCand: begin
        // fetch candidate ci
        raddr = ci_q[AddrW-1:0];
        rd_en = 1'b1;
        ji_d  = '0; lt_d = '0; eq_d = '0;
        state_d = StScan;
        rdv_d = 1'b0;
      end
      StScan: begin
        if (ji_q < count_q) begin
          raddr = ji_q[AddrW-1:0];
          rd_en = 1'b1;
          rdv_d = 1'b1;
          ji_d  = ji_q + NW'(1);
        end
        if (!rdv_q && ji_q == '0) begin
          cand_d = rd_q;
        end else if (rdv_q) begin
          if (rd_q < cand_q) lt_d = lt_q + NW'(1);
          else if (rd_q == cand_q) eq_d = eq_q + NW'(1);
        end
        if (ji_q == count_q && !rdv_q && ji_q != '0) begin
          if ((lt_q <= (count_q >> 1)) && ((count_q >> 1) < lt_q + eq_q)) begin
            med_d   = cand_q;
            state_d = StSqrt;
          end else begin
            ci_d    = ci_q + NW'(1);
            state_d = StCand;
          end
        end
      end
      StSqrt: begin
        // ji still holds the count on entry and marks the start cycle
        if (ji_q != '0) begin
          rt_start = 1'b1;
          ji_d = '0;
        end else if (rt_done) begin
          res_d.median_distance = rt_val;
          res_d.pair_count      = CountW'(count_q);
          res_d.overflow        = ovf_q;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSq && sq_done && count_q < NW'(MAX_PAIRS)) begin
      mem[count_q[AddrW-1:0]] <= sq_val;
    end
    if (rd_en) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      ci_q    <= '0;
      ji_q    <= '0;
      lt_q    <= '0;
      eq_q    <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      ci_q    <= ci_d;
      ji_q    <= ji_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
      rdv_q   <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    med_q  <= med_d;
    res_q  <= res_d;
  end

  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("input taken while busy");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(MAX_PAIRS)) else $error("pair count past capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
`endif

endmodule

// ----- rtl/core/mpd_sqdist.sv -----
// ----------------------------------------------------------------------------
// mpd_sqdist
// bit-serial squared distance: dx*dx + dy*dy by shift and add, one bit a cycle
// ----------------------------------------------------------------------------
module mpd_sqdist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mpd_pkg::CoordW:0]  dx_i,
  input  logic [mpd_pkg::CoordW:0]  dy_i,
  output logic                      done_o,
  output logic [mpd_pkg::SqW-1:0]   sq_o
);
  import mpd_pkg::*;

  localparam int unsigned MagW = CoordW + 1;
  localparam int unsigned CntW = $clog2(MagW + 1);

  logic [MagW-1:0] ax_q, ax_d, ay_q, ay_d, mx_q, mx_d, my_q, my_d;
  logic [SqW-1:0]  acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SqW-1:0]  addend;

  function automatic logic [MagW-1:0] mag(input logic [MagW-1:0] v);
    mag = v[MagW-1] ? (~v + MagW'(1)) : v;
  endfunction

  always_comb begin
    ax_d = ax_q; ay_d = ay_q; mx_d = mx_q; my_d = my_q;
    acc_d = acc_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    addend = '0;
    if (start_i) begin
      ax_d = mag(dx_i); ay_d = mag(dy_i);
      mx_d = mag(dx_i); my_d = mag(dy_i);
      acc_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (mx_q[0]) addend = addend + (SqW'(ax_q) << cnt_q);
      if (my_q[0]) addend = addend + (SqW'(ay_q) << cnt_q);
      acc_d = acc_q + addend;
      mx_d = mx_q >> 1;
      my_d = my_q >> 1;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(MagW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; ay_q <= ay_d; mx_q <= mx_d; my_q <= my_d; acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign sq_o   = acc_q;

endmodule

// ----- rtl/core/mpd_isqrt.sv -----
// ----------------------------------------------------------------------------
// mpd_isqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module mpd_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mpd_pkg::SqW-1:0]   val_i,
  output logic                      done_o,
  output logic [mpd_pkg::DistW-1:0] root_o
);
  import mpd_pkg::*;

  localparam int unsigned CntW = $clog2(DistW + 1);

  logic [SqW-1:0]   rem_q, rem_d, val_q, val_d;
  logic [DistW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [SqW-1:0]   rem_sh, trial;

  always_comb begin
    rem_d = rem_q; val_d = val_q; root_d = root_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    rem_sh = {rem_q[SqW-3:0], val_q[SqW-1:SqW-2]};
    trial  = SqW'({root_q, 2'b01});
    if (start_i) begin
      rem_d = '0; val_d = val_i; root_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = val_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DistW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DistW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; val_q <= val_d; root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- bench/tb_median_point_displacement.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_point_displacement
// self-checking bench for the median point displacement block
// ----------------------------------------------------------------------------
// Point pairs are sent over the input handshake in sets closed by a last
// pair. A bench-side model keeps the squared distances of the open set and,
// on the last pair, expects the integer root of the rank n/2 entry, the pair
// count and the overflow flag. A short table of directed sets comes first,
// then one random set running past the store capacity, then random sets
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_median_point_displacement;
  import mpd_pkg::*;

  localparam longint unsigned CycleLimit = 8000000;

  typedef struct {
    logic signed [CoordW-1:0] fx, fy, sx, sy;
    logic                     last;
    logic                     has_exp;
    mpd_out_t                 exp;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  mpd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mpd_out_t out_data_o;

  logic     in_go = 1'b0;
  logic     out_go = 1'b0;
  mpd_out_t out_seen;

  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      mismatches = 0;
  longint unsigned  cycles = 0;

  longint unsigned  set_sq[$];
  logic             set_dropped = 1'b0;
  mpd_out_t         expected_results[$];

  median_point_displacement dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // handshake state is stable mid-cycle
  always @(negedge clk_i) begin
    in_go    = in_valid_i & in_ready_o;
    out_go   = out_valid_o & out_ready_i;
    out_seen = out_data_o;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    mpd_out_t want;
    if (out_go) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: dist %0d count %0d ovf %0d",
                   out_seen.median_distance, out_seen.pair_count, out_seen.overflow);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp dist %0d count %0d ovf %0d, got dist %0d count %0d ovf %0d",
                     want.median_distance, want.pair_count, want.overflow,
                     out_seen.median_distance, out_seen.pair_count, out_seen.overflow);
          end
        end
      end
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // updates the open set and returns the result a last pair closes it with
  function automatic mpd_out_t displacement_step(mpd_in_t it);
    longint signed   dx, dy;
    longint unsigned sq;
    longint unsigned ranked[$];
    mpd_out_t        res;
    dx = longint'(it.second_x) - longint'(it.first_x);
    dy = longint'(it.second_y) - longint'(it.first_y);
    sq = longint'(dx * dx + dy * dy);
    if (set_sq.size() < MaxPairs) set_sq.push_back(sq);
    else set_dropped = 1'b1;
    res = '0;
    if (it.last_pair) begin
      ranked = set_sq;
      ranked.sort();
      res.median_distance = DistW'(root_floor(ranked[ranked.size() / 2]));
      res.pair_count      = CountW'(set_sq.size());
      res.overflow        = set_dropped;
      set_sq.delete();
      set_dropped = 1'b0;
    end
    return res;
  endfunction

  // valid stays high after a transfer unless the sender idles
  task automatic send_pair(mpd_in_t it, logic has_exp, mpd_out_t exp);
    mpd_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_go);
    res = displacement_step(it);
    if (it.last_pair) expected_results.push_back(has_exp ? exp : res);
  endtask

  function automatic logic signed [CoordW-1:0] near(logic signed [CoordW-1:0] c);
    return c + CoordW'($urandom_range(64) - 32);
  endfunction

  task automatic random_set(int unsigned n);
    mpd_in_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.first_x = CoordW'($urandom);
      it.first_y = CoordW'($urandom);
      if ($urandom_range(2) == 0) begin
        it.second_x = CoordW'($urandom);
        it.second_y = CoordW'($urandom);
      end else begin
        it.second_x = near(it.first_x);
        it.second_y = near(it.first_y);
      end
      it.last_pair = (i == n - 1);
      send_pair(it, 1'b0, '0);
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, '{17'd0, 11'd1, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 1'b1, 1'b1, '{17'd16, 11'd1, 1'b0}},
    '{-16'sd5, 16'sd7, -16'sd5, 16'sd7, 1'b1, 1'b1, '{17'd0, 11'd1, 1'b0}},
    '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b0, '0},
    '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1, 1'b0, '0},
    '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd3, 16'sd4, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd6, 16'sd8, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b1, 1'b0, '0},
    '{16'sd10, 16'sd10, 16'sd10, 16'sd10, 1'b0, 1'b0, '0},
    '{16'sd10, 16'sd10, 16'sd90, 16'sd10, 1'b0, 1'b0, '0},
    '{16'sd10, 16'sd10, 16'sd10, 16'sd50, 1'b0, 1'b0, '0},
    '{16'sd10, 16'sd10, 16'sd30, 16'sd10, 1'b1, 1'b0, '0},
    '{-16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b0, '0},
    '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
    '{16'sd0, 16'sd0, -16'sd32768, 16'sd12345, 1'b1, 1'b0, '0}
  };

  initial begin
    mpd_in_t it;
    int unsigned pcts[4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{13, 13}};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it = '{dir_rows[i].fx, dir_rows[i].fy, dir_rows[i].sx, dir_rows[i].sy,
             dir_rows[i].last};
      send_pair(it, dir_rows[i].has_exp, dir_rows[i].exp);
    end

    // one set past capacity, pairs dropped
    random_set(MaxPairs + 3);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = pcts[p][0];
      recv_stall_pct = pcts[p][1];
      for (int s = 0; s < 14; s++) begin
        random_set(($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(1, 6));
      end
    end

    in_valid_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
